[rtl/mfupr_pkg.sv]
// ----------------------------------------------------------------------------
// mfupr_pkg
// Shared types and fixed widths for the MFU page replacement block.
// ----------------------------------------------------------------------------
package mfupr_pkg;

    localparam int COUNT_W = 16;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 5;
    localparam int OPAGE_W = 16;
    localparam int OSLOT_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

[rtl/mfu_page_replacement.sv]
// ----------------------------------------------------------------------------
// mfu_page_replacement
// Most-frequently-used page replacement over a frame table held in one RAM.
// ----------------------------------------------------------------------------
// Each request reads all nf active frames in one pass through the single
//   read port of the frame RAM: one frame is examined per cycle. A new request
//   is taken only once the previous result has gone to the output register.
// Reset (synchronous, active low): table empty, timer and fault count zero,
//   frame-count configuration back to 16. The frame RAM itself is not cleared.
// ----------------------------------------------------------------------------
module mfu_page_replacement #(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration
    input  logic                                    i_cfg_we,
    input  logic [mfupr_pkg::CFG_W-1:0]             i_cfg_data,
    // request channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [15:0]                             i_page,
    input  logic                                    i_last_request,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic                                    o_hit,
    output logic [mfupr_pkg::OSLOT_W-1:0]           o_slot,
    output logic                                    o_evicted_valid,
    output logic [mfupr_pkg::OPAGE_W-1:0]           o_evicted_page,
    output logic [mfupr_pkg::FAULT_W-1:0]           o_fault_total,
    output logic                                    o_run_end
);

    // Frame index width and a counter width that can also hold NUM_FRAMES.
    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int CNT_W = mfupr_pkg::COUNT_W;
    localparam int STP_W = mfupr_pkg::STAMP_W;
    // RAM word: {page, use count, stamp}
    localparam int DW = PAGE_BITS + CNT_W + STP_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [mfupr_pkg::CFG_W-1:0] r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mfupr_pkg::CFG_W'(16);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Active frame count: zero acts as one, anything above NUM_FRAMES clips.
    logic [CW-1:0] w_nf;
    always_comb begin
        if (r_cfg == '0) begin
            w_nf = CW'(1);
        end else if (32'(r_cfg) > NUM_FRAMES) begin
            w_nf = CW'(NUM_FRAMES);
        end else begin
            w_nf = CW'(r_cfg);
        end
    end

    // ------------------------------------------------------------------
    // Frame RAM: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [DW-1:0] mem [NUM_FRAMES];
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [DW-1:0] w_mem_wdata;
    logic [AW-1:0] w_mem_raddr;
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= mem[w_mem_raddr];
    end

    // ------------------------------------------------------------------
    // Control and per-request registers
    // ------------------------------------------------------------------
    mfupr_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_filled;      // frames loaded so far
    logic [STP_W-1:0]     r_timer;       // access timer, wraps
    logic [mfupr_pkg::FAULT_W-1:0] r_fault;

    logic [PAGE_BITS-1:0] r_page;        // request being served
    logic                 r_last;
    logic [CW-1:0]        r_nf;          // frame count frozen for this request
    logic [CW-1:0]        r_loaded;      // min(filled, nf)
    logic [CW-1:0]        r_addr;        // next frame to read
    logic                 r_rd_vld;      // r_rd_data holds frame r_rd_idx
    logic [AW-1:0]        r_rd_idx;

    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;
    logic [CNT_W-1:0]     r_hit_cnt;

    logic [AW-1:0]        r_best_idx;    // current victim candidate
    logic [CNT_W-1:0]     r_best_cnt;
    logic [STP_W-1:0]     r_best_stamp;
    logic [PAGE_BITS-1:0] r_best_page;

    logic                 r_out_valid;

    // FSM outputs
    logic w_accept;
    logic w_issue;
    logic w_out_free;
    logic w_done_fire;
    logic w_last_rd;

    // Fields of the word coming out of the RAM
    logic [PAGE_BITS-1:0] w_rd_page;
    logic [CNT_W-1:0]     w_rd_cnt;
    logic [STP_W-1:0]     w_rd_stamp;

    assign w_rd_page  = r_rd_data[DW-1 -: PAGE_BITS];
    assign w_rd_cnt   = r_rd_data[STP_W +: CNT_W];
    assign w_rd_stamp = r_rd_data[STP_W-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_rd  = r_rd_vld && (CW'(r_rd_idx) == (r_nf - CW'(1)));

    // ------------------------------------------------------------------
    // Sequencer: IDLE takes a request, SCAN reads every active frame once
    // (lookup and victim search share the pass), DONE writes back and
    // hands the result to the output register.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfupr_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = mfupr_pkg::ST_SCAN;
            end
            mfupr_pkg::ST_SCAN: begin
                if (w_last_rd) n_state = mfupr_pkg::ST_DONE;
            end
            mfupr_pkg::ST_DONE: begin
                if (w_out_free) n_state = mfupr_pkg::ST_IDLE;
            end
            default: n_state = mfupr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        w_issue     = 1'b0;
        w_done_fire = 1'b0;
        unique case (r_state)
            mfupr_pkg::ST_IDLE: o_in_stall  = 1'b0;
            mfupr_pkg::ST_SCAN: w_issue     = (r_addr < r_nf);
            mfupr_pkg::ST_DONE: w_done_fire = w_out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_mem_raddr = r_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfupr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Scan datapath
    // ------------------------------------------------------------------
    logic w_rd_match;
    logic w_rd_better;

    // A match only counts among loaded frames; the first one wins.
    assign w_rd_match = r_rd_vld && !r_hit && (CW'(r_rd_idx) < r_loaded)
                        && (w_rd_page == r_page);
    // Victim order: highest count, then oldest stamp, then lowest index.
    assign w_rd_better = (r_rd_idx == '0) || (w_rd_cnt > r_best_cnt)
                         || ((w_rd_cnt == r_best_cnt) && (w_rd_stamp < r_best_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_accept) begin
                r_addr <= '0;
                r_hit  <= 1'b0;
            end else begin
                if (w_issue) r_addr <= r_addr + CW'(1);
                if (w_rd_match) r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= PAGE_BITS'(i_page);
            r_last   <= i_last_request;
            r_nf     <= w_nf;
            r_loaded <= (r_filled < w_nf) ? r_filled : w_nf;
        end
        r_rd_idx <= r_addr[AW-1:0];
        if (w_rd_match) begin
            r_hit_idx <= r_rd_idx;
            r_hit_cnt <= w_rd_cnt;
        end
        if (r_rd_vld && w_rd_better) begin
            r_best_idx   <= r_rd_idx;
            r_best_cnt   <= w_rd_cnt;
            r_best_stamp <= w_rd_stamp;
            r_best_page  <= w_rd_page;
        end
    end

    // ------------------------------------------------------------------
    // Write-back and result
    // ------------------------------------------------------------------
    logic             w_fill;
    logic             w_evict;
    logic [AW-1:0]    w_slot;
    logic [CNT_W-1:0] w_new_cnt;
    logic [mfupr_pkg::FAULT_W-1:0] w_fault_next;

    always_comb begin
        w_fill  = !r_hit && (r_filled < r_nf);
        w_evict = !r_hit && !w_fill;
        if (r_hit) begin
            w_slot = r_hit_idx;
        end else if (w_fill) begin
            w_slot = r_filled[AW-1:0];
        end else begin
            w_slot = r_best_idx;
        end
        if (!r_hit) begin
            w_new_cnt = CNT_W'(1);
        end else if (r_hit_cnt == mfupr_pkg::COUNT_MAX) begin
            w_new_cnt = r_hit_cnt;
        end else begin
            w_new_cnt = r_hit_cnt + CNT_W'(1);
        end
        w_fault_next = r_hit ? r_fault : r_fault + 32'd1;
    end

    // A hit rewrites the same page, so one word form serves every case.
    assign w_mem_we    = w_done_fire;
    assign w_mem_waddr = w_slot;
    assign w_mem_wdata = {r_page, w_new_cnt, r_timer};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_timer     <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done_fire) begin
                r_timer <= r_timer + 32'd1;
                r_fault <= w_fault_next;
                if (w_fill) r_filled <= r_filled + CW'(1);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic [31:0] w_slot_wide;
    assign w_slot_wide = 32'(w_slot);

    always_ff @(posedge i_clk) begin
        if (w_done_fire) begin
            o_hit           <= r_hit;
            o_slot          <= w_slot_wide[mfupr_pkg::OSLOT_W-1:0];
            o_evicted_valid <= w_evict;
            o_evicted_page  <= w_evict ? mfupr_pkg::OPAGE_W'(r_best_page) : '0;
            o_fault_total   <= w_fault_next;
            o_run_end       <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_filled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_filled) <= NUM_FRAMES)
        else $error("fill count beyond frame table");

    a_hit_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfupr_pkg::ST_DONE) && r_hit |-> (CW'(r_hit_idx) < r_loaded))
        else $error("hit on a frame that was never loaded");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted_valid |-> !o_hit && (32'(o_slot) < NUM_FRAMES))
        else $error("eviction reported on a hit");

    a_done_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_fire |=> o_out_valid && (r_state == mfupr_pkg::ST_IDLE))
        else $error("result not presented after write-back");
`endif

endmodule
